// File: rtl/rotated_exit_angle_macros.svh
// Assertion macros used by the RTL that checks itself.
`ifndef ROTATED_EXIT_ANGLE_MACROS_SVH
`define ROTATED_EXIT_ANGLE_MACROS_SVH

// Check that exp holds in the same cycle as cond.
`define REA_ASSERT_NOW(label, cond, exp, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (exp)) \
    else $error(msg);

// Check that exp holds in the cycle after cond.
`define REA_ASSERT_NEXT(label, cond, exp, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (exp)) \
    else $error(msg);

`endif

// File: rtl/rea_pkg.sv
package rea_pkg;

  localparam int ANGLE_FRAC_BITS = 14;
  localparam int CORDIC_STAGES   = 16;
  localparam int WFRAC           = 30;
  localparam int SHIFT           = WFRAC - ANGLE_FRAC_BITS;
  localparam int SQRT_STAGES     = 32;
  localparam int NLANE           = 4;
  localparam int IDX_W           = 5;

  // Widths of the datapath words
  localparam int ANG_W  = 36;  // Q30 angle before reduction
  localparam int RA_W   = 33;  // Q30 residual or accumulated angle
  localparam int TRIG_W = 33;  // Q30 sine, cosine and vector parts
  localparam int SQ_W   = 64;  // Q60 squared length
  localparam int VEC_W  = 36;  // vectoring CORDIC parts

  localparam int PIPE_DEPTH = 4 + CORDIC_STAGES + 4 + SQRT_STAGES + CORDIC_STAGES;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [TRIG_W-1:0] GAIN_Q30   = 33'sd652032874;
  localparam logic signed [ANG_W-1:0] HALF_LSB    = 36'sd1 <<< (SHIFT - 1);
  localparam logic signed [ANG_W-1:0] EXIT_LIM    = (HALF_PI_Q30 + HALF_LSB) >>> SHIFT;

  // Lane order of the rotation CORDIC
  localparam int LANE_THETA = 0;
  localparam int LANE_BETA  = 1;
  localparam int LANE_ROTY  = 2;
  localparam int LANE_ROTX  = 3;

  // Configuration register indexes
  localparam logic CFG_INCIDENCE = 1'b0;
  localparam logic CFG_TILT      = 1'b1;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [RA_W-1:0]   a;
    logic                     neg;
  } rot_t;

  typedef struct packed {
    logic [SQ_W-1:0]          v;
    logic [SQ_W-1:0]          r;
    logic signed [TRIG_W-1:0] z;
  } sqrt_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [RA_W-1:0]  ang;
    logic                    zero;
  } vec_t;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic signed [RA_W-1:0] atan_q30(input logic [IDX_W-1:0] idx);
    case (idx)
      5'd0:  return 33'sd843314857;
      5'd1:  return 33'sd497837829;
      5'd2:  return 33'sd263043837;
      5'd3:  return 33'sd133525159;
      5'd4:  return 33'sd67021687;
      5'd5:  return 33'sd33543516;
      5'd6:  return 33'sd16775851;
      5'd7:  return 33'sd8388437;
      5'd8:  return 33'sd4194283;
      5'd9:  return 33'sd2097149;
      5'd10: return 33'sd1048576;
      5'd11: return 33'sd524288;
      5'd12: return 33'sd262144;
      5'd13: return 33'sd131072;
      5'd14: return 33'sd65536;
      5'd15: return 33'sd32768;
      5'd16: return 33'sd16384;
      5'd17: return 33'sd8192;
      5'd18: return 33'sd4096;
      5'd19: return 33'sd2048;
      5'd20: return 33'sd1024;
      5'd21: return 33'sd512;
      5'd22: return 33'sd256;
      5'd23: return 33'sd128;
      5'd24: return 33'sd64;
      5'd25: return 33'sd32;
      5'd26: return 33'sd16;
      5'd27: return 33'sd8;
      default: return '0;
    endcase
  endfunction

  // Q30 product with floor rounding
  function automatic logic signed [TRIG_W-1:0] qmul(input logic signed [TRIG_W-1:0] a,
                                                    input logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b;
    return TRIG_W'(p >>> WFRAC);
  endfunction

endpackage

// File: rtl/rotated_exit_angle.sv
// Exit angle of a rotated detector direction. One word enters per cycle while
// in_stall is low, and one result word leaves per word after it has passed the
// pipeline: input and three angle reduction stages, 16 rotation CORDIC cells in
// four lanes, four product stages, 32 square root cells, 16 vectoring CORDIC cells
// and the output register. A stall on the output freezes the pipeline only while
// its last stage holds a word.
`include "rotated_exit_angle_macros.svh"

module rotated_exit_angle import rea_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_polar_angle,
  input  logic signed [17:0] in_azimuth_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_exit_angle
);

  logic signed [15:0]       inc_r;
  logic signed [16:0]       tilt_r;
  logic [PIPE_DEPTH-1:0]    vld_r;
  logic                     en;
  logic                     out_valid_r;
  logic signed [15:0]       out_exit_angle_r;

  logic signed [ANG_W-1:0]  ang0_r [NLANE];
  logic signed [ANG_W-1:0]  ang1_r [NLANE];
  logic signed [ANG_W-1:0]  ang2_r [NLANE];
  rot_t                     fold_r [NLANE];
  rot_t                     rot_q  [CORDIC_STAGES+1][NLANE];
  logic signed [TRIG_W-1:0] sin_w  [NLANE];
  logic signed [TRIG_W-1:0] cos_w  [NLANE];

  logic signed [TRIG_W-1:0] x_r, y_r, z_r, sy_r, cy_r, sx1_r, cx1_r;
  logic signed [TRIG_W-1:0] x1_r, z1_r, y1_r, sx2_r, cx2_r;
  logic signed [TRIG_W-1:0] x1b_r, y2_r, z2_r;
  logic signed [2*TRIG_W-1:0] px_w, py_w;
  sqrt_t                    sqrt_q [SQRT_STAGES+1];
  sqrt_t                    sq_r;
  vec_t                     vec_q  [CORDIC_STAGES+1];
  logic signed [RA_W:0]     rnd_w;
  logic signed [RA_W:0]     res_w;
  logic signed [15:0]       exit_nxt;

  function automatic logic signed [ANG_W-1:0] wrap_2pi(input logic signed [ANG_W-1:0] a);
    if (a >= TWO_PI_Q30) begin
      return a - TWO_PI_Q30;
    end else if (a <= -TWO_PI_Q30) begin
      return a + TWO_PI_Q30;
    end
    return a;
  endfunction

  function automatic logic signed [ANG_W-1:0] wrap_pi(input logic signed [ANG_W-1:0] a);
    if (a >= PI_Q30) begin
      return a - TWO_PI_Q30;
    end else if (a < -PI_Q30) begin
      return a + TWO_PI_Q30;
    end
    return a;
  endfunction

  function automatic rot_t fold_half(input logic signed [ANG_W-1:0] a);
    rot_t t;
    logic signed [ANG_W-1:0] f;
    f     = a;
    t.neg = 1'b0;
    if (a > HALF_PI_Q30) begin
      f     = a - PI_Q30;
      t.neg = 1'b1;
    end else if (a < -HALF_PI_Q30) begin
      f     = a + PI_Q30;
      t.neg = 1'b1;
    end
    t.x = GAIN_Q30;
    t.y = '0;
    t.a = RA_W'(f);
    return t;
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r  <= '0;
      tilt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INCIDENCE: inc_r  <= cfg_wdata[15:0];
        CFG_TILT:      tilt_r <= cfg_wdata;
      endcase
    end
  end

  // Advance unless a held result blocks the last stage
  assign en       = !out_valid_r || !out_stall || !vld_r[PIPE_DEPTH-1];
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // Convert to Q30 and reduce into [-pi/2, pi/2]
  always_ff @(posedge clk) begin
    if (en) begin
      ang0_r[LANE_THETA] <= ANG_W'(in_polar_angle) <<< SHIFT;
      ang0_r[LANE_BETA]  <= ANG_W'(in_azimuth_angle) <<< SHIFT;
      ang0_r[LANE_ROTY]  <= HALF_PI_Q30 + (ANG_W'(inc_r) <<< SHIFT);
      ang0_r[LANE_ROTX]  <= ANG_W'(tilt_r) <<< SHIFT;
      for (int l = 0; l < NLANE; l++) begin
        ang1_r[l] <= wrap_2pi(ang0_r[l]);
        ang2_r[l] <= wrap_pi(ang1_r[l]);
        fold_r[l] <= fold_half(ang2_r[l]);
      end
    end
  end

  // Rotation CORDIC lanes
  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    assign rot_q[0][l] = fold_r[l];
    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
      rea_rot_cell u_cell (
        .clk       (clk),
        .en        (en),
        .stage_idx (IDX_W'(s)),
        .d         (rot_q[s][l]),
        .q         (rot_q[s+1][l])
      );
    end
    assign sin_w[l] = rot_q[CORDIC_STAGES][l].neg ? -rot_q[CORDIC_STAGES][l].y
                                                  : rot_q[CORDIC_STAGES][l].y;
    assign cos_w[l] = rot_q[CORDIC_STAGES][l].neg ? -rot_q[CORDIC_STAGES][l].x
                                                  : rot_q[CORDIC_STAGES][l].x;
  end

  // Form the vector, rotate about y, then about x, then square
  always_comb begin
    px_w = x1b_r * x1b_r;
    py_w = y2_r * y2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= qmul(sin_w[LANE_THETA], cos_w[LANE_BETA]);
      y_r   <= qmul(sin_w[LANE_THETA], sin_w[LANE_BETA]);
      z_r   <= cos_w[LANE_THETA];
      sy_r  <= sin_w[LANE_ROTY];
      cy_r  <= cos_w[LANE_ROTY];
      sx1_r <= sin_w[LANE_ROTX];
      cx1_r <= cos_w[LANE_ROTX];

      x1_r  <= qmul(cy_r, x_r) - qmul(sy_r, z_r);
      z1_r  <= qmul(sy_r, x_r) + qmul(cy_r, z_r);
      y1_r  <= y_r;
      sx2_r <= sx1_r;
      cx2_r <= cx1_r;

      y2_r  <= qmul(cx2_r, y1_r) + qmul(sx2_r, z1_r);
      z2_r  <= qmul(cx2_r, z1_r) - qmul(sx2_r, y1_r);
      x1b_r <= x1_r;

      sq_r.v <= SQ_W'(px_w) + SQ_W'(py_w);
      sq_r.r <= '0;
      sq_r.z <= z2_r;
    end
  end

  // Square root cells
  assign sqrt_q[0] = sq_r;
  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
    rea_sqrt_cell u_cell (
      .clk       (clk),
      .en        (en),
      .stage_idx (IDX_W'(s)),
      .d         (sqrt_q[s]),
      .q         (sqrt_q[s+1])
    );
  end

  // Vectoring CORDIC on (rho, z)
  assign vec_q[0] = '{x:    VEC_W'(sqrt_q[SQRT_STAGES].r),
                      y:    VEC_W'(sqrt_q[SQRT_STAGES].z),
                      ang:  '0,
                      zero: (sqrt_q[SQRT_STAGES].z == '0)};

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_vec
    rea_vec_cell u_cell (
      .clk       (clk),
      .en        (en),
      .stage_idx (IDX_W'(s)),
      .d         (vec_q[s]),
      .q         (vec_q[s+1])
    );
  end

  // Round, clamp and force zero when z is zero
  always_comb begin
    rnd_w = (RA_W+1)'(vec_q[CORDIC_STAGES].ang) + (RA_W+1)'(HALF_LSB);
    res_w = rnd_w >>> SHIFT;
    if (vec_q[CORDIC_STAGES].zero) begin
      exit_nxt = '0;
    end else if (res_w > (RA_W+1)'(EXIT_LIM)) begin
      exit_nxt = 16'(EXIT_LIM);
    end else if (res_w < -(RA_W+1)'(EXIT_LIM)) begin
      exit_nxt = -16'(EXIT_LIM);
    end else begin
      exit_nxt = 16'(res_w);
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_exit_angle_r <= exit_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_exit_angle = out_exit_angle_r;

  `REA_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld_r[0], "accepted word lost")
  `REA_ASSERT_NOW(a_stall_cause, in_stall, out_valid_r && out_stall && vld_r[PIPE_DEPTH-1], "stall without a blocked result")
  `REA_ASSERT_NOW(a_exit_range, out_valid, (out_exit_angle <= 16'(EXIT_LIM)) && (out_exit_angle >= -16'(EXIT_LIM)), "exit angle out of range")

endmodule

// File: rtl/rea_rot_cell.sv
module rea_rot_cell import rea_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] stage_idx,
  input  rot_t             d,
  output rot_t             q
);

  rot_t q_r;
  rot_t q_nxt;

  // Turn toward zero residual angle
  always_comb begin
    q_nxt = d;
    if (d.a >= 0) begin
      q_nxt.x = d.x - (d.y >>> stage_idx);
      q_nxt.y = d.y + (d.x >>> stage_idx);
      q_nxt.a = d.a - atan_q30(stage_idx);
    end else begin
      q_nxt.x = d.x + (d.y >>> stage_idx);
      q_nxt.y = d.y - (d.x >>> stage_idx);
      q_nxt.a = d.a + atan_q30(stage_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// File: rtl/rea_sqrt_cell.sv
module rea_sqrt_cell import rea_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] stage_idx,
  input  sqrt_t            d,
  output sqrt_t            q
);

  sqrt_t           q_r;
  sqrt_t           q_nxt;
  logic [6:0]      sh;
  logic [SQ_W-1:0] one_w;
  logic [SQ_W-1:0] trial;

  // Settle one root bit per cell
  always_comb begin
    sh    = 7'd62 - {1'b0, stage_idx, 1'b0};
    one_w = 64'd1 << sh;
    trial = d.r + one_w;
    q_nxt = d;
    if (d.v >= trial) begin
      q_nxt.v = d.v - trial;
      q_nxt.r = (d.r >> 1) + one_w;
    end else begin
      q_nxt.r = d.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// File: rtl/rea_vec_cell.sv
module rea_vec_cell import rea_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] stage_idx,
  input  vec_t             d,
  output vec_t             q
);

  vec_t q_r;
  vec_t q_nxt;

  // Rotate toward y = 0 and collect the angle
  always_comb begin
    q_nxt = d;
    if (d.y > 0) begin
      q_nxt.x   = d.x + (d.y >>> stage_idx);
      q_nxt.y   = d.y - (d.x >>> stage_idx);
      q_nxt.ang = d.ang + atan_q30(stage_idx);
    end else begin
      q_nxt.x   = d.x - (d.y >>> stage_idx);
      q_nxt.y   = d.y + (d.x >>> stage_idx);
      q_nxt.ang = d.ang - atan_q30(stage_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule
